>>> design/token_dispense_controller_assert.svh
// Assertion macros for the token dispense controller.
`ifndef TOKEN_DISPENSE_CONTROLLER_ASSERT_SVH
`define TOKEN_DISPENSE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TDC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tdc assertion failed");

// Next-cycle implication, checked outside reset.
`define TDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tdc assertion failed");

`endif

>>> design/tdc_pkg.sv
// Shared types and constants of the token dispense controller.
package tdc_pkg;

    localparam int RING_DEPTH = 8;
    localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam logic [15:0] SETTLE_RESET = 16'd500;

    // input commands (codes 2 and 3 behave as a query)
    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_POLL    = 2'd1;

    // request outcomes
    localparam logic [2:0] OUT_STARTED    = 3'd0;
    localparam logic [2:0] OUT_IDEMPOTENT = 3'd1;
    localparam logic [2:0] OUT_REUSED     = 3'd2;
    localparam logic [2:0] OUT_BUSY       = 3'd3;
    localparam logic [2:0] OUT_FAULT      = 3'd4;
    localparam logic [2:0] OUT_NOT_REQ    = 3'd5;

    localparam logic [1:0] DEV_IDLE        = 2'd0;
    localparam logic [1:0] DEV_DISPENSING  = 2'd1;
    localparam logic [1:0] DEV_FAULT       = 2'd2;

    localparam logic [1:0] FLT_NONE        = 2'd0;
    localparam logic [1:0] FLT_JAM         = 2'd1;
    localparam logic [1:0] FLT_HOPPER      = 2'd2;

    localparam logic [1:0] TX_IDLE         = 2'd0;
    localparam logic [1:0] TX_DISPENSING   = 2'd1;
    localparam logic [1:0] TX_DONE         = 2'd2;
    localparam logic [1:0] TX_ERROR        = 2'd3;

    localparam logic [1:0] TXERR_NONE      = 2'd0;
    localparam logic [1:0] TXERR_JAM       = 2'd1;
    localparam logic [1:0] TXERR_HOPPER    = 2'd3;

    // transaction view, laid out as the 29-bit ring record
    typedef struct packed {
        logic [7:0] ec;
        logic [1:0] ek;
        logic       rel;
        logic [7:0] disp;
        logic [7:0] qty;
        logic [1:0] st;
    } t_tx_view;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [7:0]  quantity;
        logic [7:0]  pulse_count;
        logic [7:0]  hop_err;
        logic        jam_seen;
        logic [31:0] now_ms;
    } t_req;

    typedef struct packed {
        logic [2:0] outcome;
        logic       motor_start;
        logic       motor_stop;
        logic [1:0] device_state;
        logic [1:0] fault_kind;
        logic [7:0] flt_code;
        t_tx_view   tx;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic                  load;
        logic                  step;
        logic                  exec;
        logic [RING_IDX_W-1:0] idx;
    } t_dp_cmd;

endpackage

>>> design/tdc_if.sv
// Request, response and configuration channel interfaces.
interface tdc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [7:0]  quantity;
    logic [7:0]  pulse_count;
    logic [7:0]  hop_err;
    logic        jam_seen;
    logic [31:0] now_ms;

    modport source (output valid, cmd, key_hi, key_lo, quantity, pulse_count, hop_err,
                    jam_seen, now_ms, input ready);
    modport sink (input valid, cmd, key_hi, key_lo, quantity, pulse_count, hop_err,
                  jam_seen, now_ms, output ready);
endinterface

interface tdc_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] outcome;
    logic       motor_start;
    logic       motor_stop;
    logic [1:0] device_state;
    logic [1:0] fault_kind;
    logic [7:0] flt_code;
    logic [1:0] tx_state;
    logic [7:0] tx_quantity;
    logic [7:0] tx_dispensed;
    logic       tx_reliable;
    logic [1:0] tx_error_kind;
    logic [7:0] tx_error_code;

    modport source (output valid, outcome, motor_start, motor_stop, device_state, fault_kind,
                    flt_code, tx_state, tx_quantity, tx_dispensed, tx_reliable,
                    tx_error_kind, tx_error_code, input ready);
    modport sink (input valid, outcome, motor_start, motor_stop, device_state, fault_kind,
                  flt_code, tx_state, tx_quantity, tx_dispensed, tx_reliable,
                  tx_error_kind, tx_error_code, output ready);
endinterface

interface tdc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] settle_time_ms;

    modport source (output valid, settle_time_ms, input ready);
    modport sink (input valid, settle_time_ms, output ready);
endinterface

>>> design/tdc_ctrl.sv
// Sequencer: capture, ring search, execute and response handoff.
module tdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output tdc_pkg::t_dp_cmd o_cmd
);
    import tdc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [RING_IDX_W-1:0] r_idx, n_idx;
    logic                  r_rsp_valid, n_rsp_valid;
    logic                  rsp_free;

    assign rsp_free    = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (r_idx == RING_IDX_W'(RING_DEPTH - 1)) begin
                    n_state = S_EXEC;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EXEC: begin
                // state update and response load happen together
                if (rsp_free) begin
                    o_cmd.exec  = 1'b1;
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

>>> design/tdc_dp.sv
// Datapath: active slot, fault latch, finished-transaction ring, response register.
module tdc_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tdc_pkg::t_dp_cmd i_cmd,
    input  tdc_pkg::t_req    i_req,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_settle,
    output tdc_pkg::t_rsp    o_rsp
);
    import tdc_pkg::*;

    // configuration
    logic [15:0] r_settle_time;

    // captured item and search result
    t_req        r_req;
    logic        r_found;
    t_tx_view    r_frec;

    // active slot and fault latch
    logic [63:0] r_act_khi, n_act_khi;
    logic [63:0] r_act_klo, n_act_klo;
    logic [7:0]  r_act_qty, n_act_qty;
    logic [7:0]  r_act_cnt, n_act_cnt;
    logic        r_busy, n_busy;
    logic        r_start_pend, n_start_pend;
    logic        r_settling, n_settling;
    logic [31:0] r_settle_start, n_settle_start;
    logic [1:0]  r_fault, n_fault;
    logic [7:0]  r_fcode, n_fcode;

    // ring of finished transactions
    logic [63:0]           r_ring_khi [RING_DEPTH];
    logic [63:0]           r_ring_klo [RING_DEPTH];
    t_tx_view              r_ring_rec [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_ring_vld;
    logic [RING_IDX_W-1:0] r_ring_next, n_ring_next;

    t_rsp        r_rsp, n_rsp;

    logic        key_zero;
    logic        ring_hit;
    logic        act_eq;
    logic        ended;
    logic [1:0]  end_st;
    logic [1:0]  end_ek;
    logic [7:0]  end_ec;
    logic [31:0] elapsed;
    t_tx_view    old_act_view;
    t_tx_view    lookup_view;
    t_tx_view    fin_view;
    t_tx_view    new_act_view;

    assign key_zero = (r_req.key_hi == '0) && (r_req.key_lo == '0);
    assign ring_hit = r_ring_vld[i_cmd.idx] && !key_zero &&
                      (r_ring_khi[i_cmd.idx] == r_req.key_hi) &&
                      (r_ring_klo[i_cmd.idx] == r_req.key_lo);
    assign act_eq   = (r_req.key_hi == r_act_khi) && (r_req.key_lo == r_act_klo);
    assign elapsed  = r_req.now_ms - r_settle_start;

    always_comb begin
        old_act_view      = '0;
        old_act_view.st   = r_busy ? TX_DISPENSING : TX_IDLE;
        old_act_view.qty  = r_act_qty;
        old_act_view.disp = r_act_cnt;
        old_act_view.rel  = 1'b1;

        lookup_view     = '0;
        lookup_view.rel = 1'b1;
        if (act_eq) begin
            lookup_view = old_act_view;
        end else if (r_found) begin
            lookup_view = r_frec;
        end
    end

    always_comb begin
        n_act_khi      = r_act_khi;
        n_act_klo      = r_act_klo;
        n_act_qty      = r_act_qty;
        n_act_cnt      = r_act_cnt;
        n_busy         = r_busy;
        n_start_pend   = r_start_pend;
        n_settling     = r_settling;
        n_settle_start = r_settle_start;
        n_fault        = r_fault;
        n_fcode        = r_fcode;
        n_ring_next    = r_ring_next;
        ended          = 1'b0;
        end_st         = TX_DONE;
        end_ek         = TXERR_NONE;
        end_ec         = '0;
        fin_view       = '0;
        new_act_view   = '0;
        n_rsp          = '0;
        n_rsp.outcome  = OUT_NOT_REQ;

        if (r_req.cmd == CMD_REQUEST) begin
            priority if (r_busy && act_eq) begin
                n_rsp.outcome = (r_req.quantity == r_act_qty) ? OUT_IDEMPOTENT : OUT_REUSED;
            end else if (r_found) begin
                n_rsp.outcome = (r_req.quantity == r_frec.qty) ? OUT_IDEMPOTENT : OUT_REUSED;
            end else if (r_busy) begin
                n_rsp.outcome = OUT_BUSY;
            end else if (r_fault != FLT_NONE) begin
                n_rsp.outcome = OUT_FAULT;
            end else begin
                n_act_khi     = r_req.key_hi;
                n_act_klo     = r_req.key_lo;
                n_act_qty     = r_req.quantity;
                n_act_cnt     = '0;
                n_busy        = 1'b1;
                n_start_pend  = 1'b1;
                n_rsp.outcome = OUT_STARTED;
            end
        end else if (r_req.cmd == CMD_POLL) begin
            priority if (r_start_pend) begin
                n_start_pend      = 1'b0;
                n_settling        = 1'b0;
                n_rsp.motor_start = 1'b1;
            end else if (r_req.hop_err != '0) begin
                if (r_fault == FLT_NONE) begin
                    n_fault = FLT_HOPPER;
                    n_fcode = r_req.hop_err;
                end
                if (r_busy) begin
                    ended            = 1'b1;
                    end_st           = TX_ERROR;
                    end_ek           = TXERR_HOPPER;
                    end_ec           = r_req.hop_err;
                    n_rsp.motor_stop = 1'b1;
                end
            end else if (r_busy) begin
                n_act_cnt = r_req.pulse_count;
                priority if (r_settling) begin
                    if (elapsed >= {16'd0, r_settle_time}) begin
                        ended = 1'b1;
                    end
                end else if (r_req.pulse_count >= r_act_qty) begin
                    n_rsp.motor_stop = 1'b1;
                    n_settling       = 1'b1;
                    n_settle_start   = r_req.now_ms;
                end else if (r_req.jam_seen) begin
                    if (r_fault == FLT_NONE) begin
                        n_fault = FLT_JAM;
                        n_fcode = '0;
                    end
                    ended            = 1'b1;
                    end_st           = TX_ERROR;
                    end_ek           = TXERR_JAM;
                    n_rsp.motor_stop = 1'b1;
                end else begin
                    n_settling = r_settling;
                end
            end else begin
                n_busy = r_busy;
            end
        end

        // ending moves the slot into the ring and clears it
        fin_view.st   = end_st;
        fin_view.qty  = r_act_qty;
        fin_view.disp = n_act_cnt;
        fin_view.rel  = 1'b1;
        fin_view.ek   = end_ek;
        fin_view.ec   = end_ec;
        if (ended) begin
            n_act_khi    = '0;
            n_act_klo    = '0;
            n_act_qty    = '0;
            n_act_cnt    = '0;
            n_busy       = 1'b0;
            n_start_pend = 1'b0;
            n_settling   = 1'b0;
            n_ring_next  = (r_ring_next == RING_IDX_W'(RING_DEPTH - 1)) ? '0
                                                                        : r_ring_next + 1'b1;
        end

        new_act_view.st   = n_busy ? TX_DISPENSING : TX_IDLE;
        new_act_view.qty  = n_act_qty;
        new_act_view.disp = n_act_cnt;
        new_act_view.rel  = 1'b1;

        if (r_req.cmd == CMD_POLL) begin
            n_rsp.tx = ended ? fin_view : new_act_view;
        end else if (r_req.cmd == CMD_REQUEST && n_rsp.outcome == OUT_STARTED) begin
            n_rsp.tx = new_act_view;
        end else begin
            n_rsp.tx = lookup_view;
        end

        n_rsp.device_state = (n_fault != FLT_NONE) ? DEV_FAULT
                                                   : (n_busy ? DEV_DISPENSING : DEV_IDLE);
        n_rsp.fault_kind   = n_fault;
        n_rsp.flt_code     = n_fcode;
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_time  <= SETTLE_RESET;
            r_found        <= 1'b0;
            r_act_khi      <= '0;
            r_act_klo      <= '0;
            r_act_qty      <= '0;
            r_act_cnt      <= '0;
            r_busy         <= 1'b0;
            r_start_pend   <= 1'b0;
            r_settling     <= 1'b0;
            r_settle_start <= '0;
            r_fault        <= FLT_NONE;
            r_fcode        <= '0;
            r_ring_vld     <= '0;
            r_ring_next    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_settle_time <= i_cfg_settle;
            end
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (i_cmd.step && !r_found && ring_hit) begin
                r_found <= 1'b1;
            end
            if (i_cmd.exec) begin
                r_act_khi      <= n_act_khi;
                r_act_klo      <= n_act_klo;
                r_act_qty      <= n_act_qty;
                r_act_cnt      <= n_act_cnt;
                r_busy         <= n_busy;
                r_start_pend   <= n_start_pend;
                r_settling     <= n_settling;
                r_settle_start <= n_settle_start;
                r_fault        <= n_fault;
                r_fcode        <= n_fcode;
                r_ring_next    <= n_ring_next;
                if (ended) begin
                    r_ring_vld[r_ring_next] <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.step && !r_found && ring_hit) begin
            r_frec <= r_ring_rec[i_cmd.idx];
        end
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
            if (ended) begin
                r_ring_khi[r_ring_next] <= r_act_khi;
                r_ring_klo[r_ring_next] <= r_act_klo;
                r_ring_rec[r_ring_next] <= fin_view;
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

>>> design/token_dispense_controller.sv
// Top level of the token dispense controller.
//
//  channel  dir  payload                                        handshake
//  i_req    in   cmd, key_hi/lo, quantity, poll fields, now_ms  valid/ready
//  o_rsp    out  outcome, motor flags, device/fault, tx view    valid/ready
//  i_cfg    in   settle_time_ms                                 valid/ready (always ready)
//
//  Each request passes through a capture step, one ring key compare per
//  entry, then an execute step that updates state. The ring search loop
//  does one 128-bit compare per cycle.
//  Execute holds while the response register is full and not being taken.
//  Reset clears the active slot, the fault latch and the ring valid bits at
//  once; no clearing pass. settle_time_ms resets to 500.
module token_dispense_controller (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tdc_req_if.sink   i_req,
    tdc_rsp_if.source o_rsp,
    tdc_cfg_if.sink   i_cfg
);
    import tdc_pkg::*;

`include "token_dispense_controller_assert.svh"

    t_dp_cmd dp_cmd;
    t_req    req;
    t_rsp    rsp;
    logic    req_ready;
    logic    rsp_valid;

    // pack the request channel for the datapath
    assign req.cmd          = i_req.cmd;
    assign req.key_hi       = i_req.key_hi;
    assign req.key_lo       = i_req.key_lo;
    assign req.quantity     = i_req.quantity;
    assign req.pulse_count  = i_req.pulse_count;
    assign req.hop_err      = i_req.hop_err;
    assign req.jam_seen     = i_req.jam_seen;
    assign req.now_ms       = i_req.now_ms;

    assign i_req.ready = req_ready;
    assign i_cfg.ready = 1'b1;

    tdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (dp_cmd)
    );

    tdc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_req        (req),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_settle (i_cfg.settle_time_ms),
        .o_rsp        (rsp)
    );

    // response channel
    assign o_rsp.valid         = rsp_valid;
    assign o_rsp.outcome       = rsp.outcome;
    assign o_rsp.motor_start   = rsp.motor_start;
    assign o_rsp.motor_stop    = rsp.motor_stop;
    assign o_rsp.device_state  = rsp.device_state;
    assign o_rsp.fault_kind    = rsp.fault_kind;
    assign o_rsp.flt_code      = rsp.flt_code;
    assign o_rsp.tx_state      = rsp.tx.st;
    assign o_rsp.tx_quantity   = rsp.tx.qty;
    assign o_rsp.tx_dispensed  = rsp.tx.disp;
    assign o_rsp.tx_reliable   = rsp.tx.rel;
    assign o_rsp.tx_error_kind = rsp.tx.ek;
    assign o_rsp.tx_error_code = rsp.tx.ec;

    // one request in flight: capture drops ready until execute completes
    `TDC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req.valid && req_ready, !req_ready)

    // a poll never starts and stops the motor in the same step
    `TDC_ASSERT_IMPLY(a_motor_excl, i_clk, i_rst_n, rsp_valid, !(rsp.motor_start && rsp.motor_stop))

    // device fault state tracks the sticky fault latch
    `TDC_ASSERT_IMPLY(a_fault_state, i_clk, i_rst_n, rsp_valid,
        (rsp.device_state == DEV_FAULT) == (rsp.fault_kind != FLT_NONE))

    // a started request leaves the device dispensing
    `TDC_ASSERT_IMPLY(a_start_disp, i_clk, i_rst_n, rsp_valid && (rsp.outcome == OUT_STARTED),
        (rsp.device_state == DEV_DISPENSING) && (rsp.tx.st == TX_DISPENSING))

endmodule
